### hdl/scs_pkg.sv
`timescale 1ns / 1ps

package scs_pkg;

   // Store geometry: 256 two-bit codes, kept as 16 rows of 16 codes
   localparam int COEFF_COUNT = 256;
   localparam int ROW_CODES   = 16;
   localparam int CODE_W      = 2;
   localparam int ROW_BITS    = ROW_CODES * CODE_W;
   localparam int ROW_COUNT   = COEFF_COUNT / ROW_CODES;
   localparam int ROW_ADDR_W  = $clog2(ROW_COUNT);
   localparam int SLOT_W      = $clog2(ROW_CODES);
   localparam int INDEX_W     = $clog2(COEFF_COUNT);

   localparam logic [INDEX_W-1:0]    LAST_POSITION = INDEX_W'(COEFF_COUNT - 1);
   localparam logic [ROW_ADDR_W-1:0] LAST_ROW      = ROW_ADDR_W'(ROW_COUNT - 1);

   localparam logic [3:0] SIGN_BYTES = 4'd8;

   localparam logic [CODE_W-1:0] CODE_ZERO  = 2'd0;
   localparam logic [CODE_W-1:0] CODE_PLUS  = 2'd1;
   localparam logic [CODE_W-1:0] CODE_MINUS = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic {
      CMD_CLEAR = 1'b0,
      CMD_SWAP  = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [INDEX_W-1:0] idx;
      logic [INDEX_W-1:0] pos;
      logic [CODE_W-1:0]  code;
      logic               last;
   } cmd_type;

endpackage

### hdl/scs_ram.sv
`timescale 1ns / 1ps

module scs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

### hdl/scs_front.sv
`timescale 1ns / 1ps

module scs_front #(
   parameter int FIRST_POSITION = 196
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_stream_byte,
   input  logic                req_start_req,
   input  logic                q_full,
   output logic                push,
   output scs_pkg::cmd_type    push_cmd
);

   localparam logic [scs_pkg::INDEX_W-1:0] FIRST_POS = scs_pkg::INDEX_W'(FIRST_POSITION);

   logic                          running_ff, running_in;
   logic [3:0]                    sign_seen_ff, sign_seen_in;
   logic [63:0]                   sign_word_ff, sign_word_in;
   logic [scs_pkg::INDEX_W-1:0]   pos_ff, pos_in;
   logic [5:0]                    sign_index_ff, sign_index_in;
   logic                          accept;

   assign req_stall = q_full;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      running_in    = running_ff;
      sign_seen_in  = sign_seen_ff;
      sign_word_in  = sign_word_ff;
      pos_in        = pos_ff;
      sign_index_in = sign_index_ff;
      push          = 1'b0;
      push_cmd.kind = scs_pkg::CMD_CLEAR;
      push_cmd.idx  = req_stream_byte;
      push_cmd.pos  = pos_ff;
      push_cmd.code = sign_word_ff[sign_index_ff] ? scs_pkg::CODE_MINUS : scs_pkg::CODE_PLUS;
      push_cmd.last = (pos_ff == scs_pkg::LAST_POSITION);
      if (accept) begin
         if (req_start_req) begin
            // restart: the marked byte is the first sign byte
            running_in    = 1'b1;
            sign_word_in  = {56'd0, req_stream_byte};
            sign_seen_in  = 4'd1;
            pos_in        = FIRST_POS;
            sign_index_in = 6'd0;
            push          = 1'b1;
         end else if (running_ff) begin
            if (sign_seen_ff < scs_pkg::SIGN_BYTES) begin
               sign_word_in[{sign_seen_ff[2:0], 3'b000} +: 8] = req_stream_byte;
               sign_seen_in = sign_seen_ff + 4'd1;
            end else if (req_stream_byte <= pos_ff) begin
               push          = 1'b1;
               push_cmd.kind = scs_pkg::CMD_SWAP;
               sign_index_in = sign_index_ff + 6'd1;
               pos_in        = pos_ff + 1'b1;
               if (pos_ff == scs_pkg::LAST_POSITION) begin
                  running_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= 1'b0;
         sign_seen_ff  <= 4'd0;
         pos_ff        <= FIRST_POS;
         sign_index_ff <= 6'd0;
      end else begin
         running_ff    <= running_in;
         sign_seen_ff  <= sign_seen_in;
         pos_ff        <= pos_in;
         sign_index_ff <= sign_index_in;
      end
   end

   always_ff @(posedge clock) begin
      sign_word_ff <= sign_word_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (push && push_cmd.kind == scs_pkg::CMD_SWAP) |-> (sign_seen_ff == scs_pkg::SIGN_BYTES))
      else $error("swap issued before the sign word was complete");

endmodule

### hdl/scs_queue.sv
`timescale 1ns / 1ps

module scs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  scs_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output scs_pkg::cmd_type head_cmd,
   output logic             empty
);

   scs_pkg::cmd_type              q_ff [scs_pkg::QUEUE_DEPTH];
   logic [scs_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [scs_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [scs_pkg::QPTR_W:0]      count_ff, count_in;

   assign full     = (count_ff == (scs_pkg::QPTR_W + 1)'(scs_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("request pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from an empty queue");

endmodule

### hdl/scs_back.sv
`timescale 1ns / 1ps

module scs_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  scs_pkg::cmd_type               head_cmd,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [scs_pkg::ROW_BITS-1:0]   rsp_coeff_word,
   output logic [scs_pkg::ROW_ADDR_W-1:0] rsp_word_index,
   output logic                           rsp_last_word
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_WRITE_B = 4'b0010,
      ST_WRITE_P = 4'b0100,
      ST_EMIT    = 4'b1000
   } state_type;

   state_type                        state_ff, state_in;
   scs_pkg::cmd_type                 cmd_ff, cmd_in;
   logic [scs_pkg::ROW_BITS-1:0]     pend_row_ff, pend_row_in;
   logic [scs_pkg::ROW_COUNT-1:0]    row_valid_ff, row_valid_in;
   logic [scs_pkg::ROW_ADDR_W-1:0]   emit_row_ff, emit_row_in;
   logic                             emit_rd_ok_ff, emit_rd_ok_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [scs_pkg::ROW_BITS-1:0]     rsp_coeff_ff;
   logic [scs_pkg::ROW_ADDR_W-1:0]   rsp_index_ff;
   logic                             rsp_last_ff;

   logic                             ram_wr_en;
   logic [scs_pkg::ROW_ADDR_W-1:0]   ram_wr_addr;
   logic [scs_pkg::ROW_BITS-1:0]     ram_wr_data;
   logic [scs_pkg::ROW_ADDR_W-1:0]   ram_rd_addr_a, ram_rd_addr_b;
   logic [scs_pkg::ROW_BITS-1:0]     ram_rd_data_a, ram_rd_data_b;

   logic [scs_pkg::ROW_ADDR_W-1:0]   row_b, row_p;
   logic [scs_pkg::SLOT_W-1:0]       slot_b, slot_p;
   logic [scs_pkg::ROW_BITS-1:0]     data_b, data_p, data_emit;
   logic [scs_pkg::CODE_W-1:0]       old_code;
   logic                             out_free, load;

   function automatic logic [scs_pkg::ROW_BITS-1:0] put_code(
      input logic [scs_pkg::ROW_BITS-1:0] row,
      input logic [scs_pkg::SLOT_W-1:0]   slot,
      input logic [scs_pkg::CODE_W-1:0]   code
   );
      logic [scs_pkg::ROW_BITS-1:0] r;
      r = row;
      r[{slot, 1'b0} +: scs_pkg::CODE_W] = code;
      return r;
   endfunction

   assign row_b  = cmd_ff.idx[scs_pkg::INDEX_W-1 -: scs_pkg::ROW_ADDR_W];
   assign row_p  = cmd_ff.pos[scs_pkg::INDEX_W-1 -: scs_pkg::ROW_ADDR_W];
   assign slot_b = cmd_ff.idx[scs_pkg::SLOT_W-1:0];
   assign slot_p = cmd_ff.pos[scs_pkg::SLOT_W-1:0];

   // rows not written since the last clear read as all zero codes
   assign data_b    = row_valid_ff[row_b] ? ram_rd_data_a : '0;
   assign data_p    = row_valid_ff[row_p] ? ram_rd_data_b : '0;
   assign data_emit = row_valid_ff[emit_row_ff] ? ram_rd_data_a : '0;
   assign old_code  = data_b[{slot_b, 1'b0} +: scs_pkg::CODE_W];

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign load     = (state_ff == ST_EMIT) & emit_rd_ok_ff & out_free;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      pend_row_in   = pend_row_ff;
      row_valid_in  = row_valid_ff;
      emit_row_in   = emit_row_ff;
      pop           = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = row_b;
      ram_wr_data   = put_code(data_b, slot_b, cmd_ff.code);
      ram_rd_addr_a = head_cmd.idx[scs_pkg::INDEX_W-1 -: scs_pkg::ROW_ADDR_W];
      ram_rd_addr_b = head_cmd.pos[scs_pkg::INDEX_W-1 -: scs_pkg::ROW_ADDR_W];
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               pop = 1'b1;
               if (head_cmd.kind == scs_pkg::CMD_CLEAR) begin
                  row_valid_in = '0;
               end else begin
                  cmd_in   = head_cmd;
                  state_in = ST_WRITE_B;
               end
            end
         end
         ST_WRITE_B: begin
            ram_wr_en           = 1'b1;
            row_valid_in[row_b] = 1'b1;
            if (row_b == row_p) begin
               // both codes in one row: copy first, then place the sign
               ram_wr_data = put_code(put_code(data_b, slot_p, old_code), slot_b, cmd_ff.code);
               emit_row_in = '0;
               state_in    = cmd_ff.last ? ST_EMIT : ST_IDLE;
            end else begin
               pend_row_in = put_code(data_p, slot_p, old_code);
               state_in    = ST_WRITE_P;
            end
         end
         ST_WRITE_P: begin
            ram_wr_en           = 1'b1;
            ram_wr_addr         = row_p;
            ram_wr_data         = pend_row_ff;
            row_valid_in[row_p] = 1'b1;
            emit_row_in         = '0;
            state_in            = cmd_ff.last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (load) begin
               emit_row_in = emit_row_ff + 1'b1;
               if (emit_row_ff == scs_pkg::LAST_ROW) begin
                  state_in = ST_IDLE;
               end
            end
            ram_rd_addr_a = emit_row_in;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      emit_rd_ok_in = (state_ff == ST_EMIT) && (state_in == ST_EMIT);
      rsp_valid_in  = load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         row_valid_ff  <= '0;
         emit_row_ff   <= '0;
         emit_rd_ok_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_valid_ff  <= row_valid_in;
         emit_row_ff   <= emit_row_in;
         emit_rd_ok_ff <= emit_rd_ok_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      pend_row_ff <= pend_row_in;
      if (load) begin
         rsp_coeff_ff <= data_emit;
         rsp_index_ff <= emit_row_ff;
         rsp_last_ff  <= (emit_row_ff == scs_pkg::LAST_ROW);
      end
   end

   scs_ram #(
      .WIDTH (scs_pkg::ROW_BITS),
      .DEPTH (scs_pkg::ROW_COUNT)
   ) u_store (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_addr_a (ram_rd_addr_a),
      .rd_data_a (ram_rd_data_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_b (ram_rd_data_b)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_coeff_word = rsp_coeff_ff;
   assign rsp_word_index = rsp_index_ff;
   assign rsp_last_word  = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !ram_wr_en)
      else $error("store written while streaming out");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_IDLE))
      else $error("request taken while a swap or stream-out is in progress");

endmodule

### hdl/sparse_challenge_sampler.sv
`timescale 1ns / 1ps

// Sparse challenge sampler: builds a 256-coefficient {0, +1, -1} polynomial
// from a byte stream. A byte with req_start_req begins a new challenge; the
// first eight bytes form the sign word, later bytes are candidate indices.
// The front end takes one byte per clock whenever its four-entry request
// queue has room. The back end owns the coefficient store (16 rows of 16
// two-bit codes, one write port); an accepted index passes from ST_IDLE
// through ST_WRITE_B alone when source and destination share a row, or
// through ST_WRITE_B and then ST_WRITE_P otherwise, and a restart is taken
// in ST_IDLE. On completion it streams the sixteen result words one per cycle
// while the result side does not stall, after a first read of the store;
// req_stall rises only while the queue is full. Restart clears the store at
// once through per-row valid bits, with no clearing pass.
module sparse_challenge_sampler #(
   parameter int FIRST_POSITION = 196
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   input  logic        req_start_req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_coeff_word,
   output logic [3:0]  rsp_word_index,
   output logic        rsp_last_word
);

   logic             q_full, q_empty, push, pop;
   scs_pkg::cmd_type push_cmd, head_cmd;

   scs_front #(
      .FIRST_POSITION (FIRST_POSITION)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .req_start_req   (req_start_req),
      .q_full          (q_full),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   scs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   scs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .head_cmd       (head_cmd),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_coeff_word (rsp_coeff_word),
      .rsp_word_index (rsp_word_index),
      .rsp_last_word  (rsp_last_word)
   );

endmodule

### bench/sparse_challenge_checker.sv
`timescale 1ns / 1ps

module sparse_challenge_checker
   import scs_pkg::*;
#(
   parameter int FIRST_POSITION = 196
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   input  logic        req_start_req,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_coeff_word,
   input  logic [3:0]  rsp_word_index,
   input  logic        rsp_last_word,
   output int          mismatches,
   output int          outstanding,
   output int          words_checked,
   output int          challenges_done,
   output int          restarts
);

   localparam int REPORT_LIMIT = 40;

   typedef struct packed {
      logic [31:0] coeff_word;
      logic [3:0]  word_index;
      logic        last_word;
   } poly_word_type;

   // Own copy of the challenge being built
   logic [CODE_W-1:0] coeffs [COEFF_COUNT];
   logic [63:0]       sign_bits;
   int                sign_bytes_taken;
   int                fill_pos;
   logic [5:0]        sign_idx;
   logic              building;
   poly_word_type     expected_words [$];

   function automatic void clear_challenge();
      foreach (coeffs[i]) coeffs[i] = CODE_ZERO;
      sign_bits        = '0;
      sign_bytes_taken = 0;
      fill_pos         = FIRST_POSITION;
      sign_idx         = '0;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < REPORT_LIMIT) begin
         $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
      end
      mismatches++;
   endtask

   // Fold one accepted request into the challenge; queue the polynomial on completion
   task automatic absorb_byte(input logic [7:0] b, input logic start);
      logic [7:0]        pos;
      logic [CODE_W-1:0] code;
      poly_word_type     w;
      int                k;
      int                j;
      if (start) begin
         if (building) begin
            restarts++;
         end
         clear_challenge();
         building = 1'b1;
      end
      if (!building) begin
         return;
      end
      if (sign_bytes_taken < SIGN_BYTES) begin
         sign_bits[8*sign_bytes_taken +: 8] = b;
         sign_bytes_taken++;
         return;
      end
      pos = 8'(fill_pos);
      if (b > pos) begin
         return;
      end
      code        = sign_bits[sign_idx] ? CODE_MINUS : CODE_PLUS;
      coeffs[pos] = coeffs[b];
      coeffs[b]   = code;
      sign_idx++;
      fill_pos    = pos + 1;
      if (fill_pos < COEFF_COUNT) begin
         return;
      end
      building = 1'b0;
      for (k = 0; k < ROW_COUNT; k++) begin
         w.coeff_word = '0;
         for (j = 0; j < ROW_CODES; j++) begin
            w.coeff_word[CODE_W*j +: CODE_W] = coeffs[ROW_CODES*k + j];
         end
         w.word_index = 4'(k);
         w.last_word  = (k == ROW_COUNT - 1);
         expected_words.push_back(w);
      end
      challenges_done++;
   endtask

   always @(posedge clock) begin : watch
      poly_word_type want;
      if (reset) begin
         clear_challenge();
         building = 1'b0;
         expected_words.delete();
         mismatches      = 0;
         words_checked   = 0;
         challenges_done = 0;
         restarts        = 0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_byte(req_stream_byte, req_start_req);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch("word with nothing outstanding", rsp_coeff_word, '0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_coeff_word !== want.coeff_word) begin
                  report_mismatch("coeff_word", rsp_coeff_word, want.coeff_word);
               end
               if (rsp_word_index !== want.word_index) begin
                  report_mismatch("word_index", 32'(rsp_word_index), 32'(want.word_index));
               end
               if (rsp_last_word !== want.last_word) begin
                  report_mismatch("last_word", 32'(rsp_last_word), 32'(want.last_word));
               end
               words_checked++;
            end
         end
      end
      outstanding <= expected_words.size();
   end

endmodule

### bench/tb_sparse_challenge_sampler.sv
`timescale 1ns / 1ps

module tb_sparse_challenge_sampler;
   import scs_pkg::*;

   localparam int FIRST_POS    = 196;
   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 40;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_stream_byte;
   logic        req_start_req;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_coeff_word;
   logic [3:0]  rsp_word_index;
   logic        rsp_last_word;

   int idle_pct      = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   int holds_asked   = 0;
   int holds_served  = 0;
   int cycle_count   = 0;
   int requests_sent = 0;

   int mismatches;
   int outstanding;
   int words_checked;
   int challenges_done;
   int restarts;

   always #2 clock = ~clock;

   sparse_challenge_sampler #(
      .FIRST_POSITION(FIRST_POS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .req_start_req   (req_start_req),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_coeff_word  (rsp_coeff_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   sparse_challenge_checker #(
      .FIRST_POSITION(FIRST_POS)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .req_start_req   (req_start_req),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_coeff_word  (rsp_coeff_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .words_checked   (words_checked),
      .challenges_done (challenges_done),
      .restarts        (restarts)
   );

   // Result side: random stall, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (holds_asked != holds_served) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles, %0d words still outstanding",
                  cycle_count, outstanding);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offer one request and hold it until it is taken
   task automatic offer_request(input logic [7:0] b, input logic start);
      while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      req_start_req   <= start;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      requests_sent++;
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   // Start, seven sign bytes, then candidates; cut_after < 0 runs to completion
   task automatic run_challenge(input int cut_after);
      int         pos;
      int         tries;
      int         pick;
      logic [7:0] b;
      offer_request(8'($urandom), 1'b1);
      repeat (SIGN_BYTES - 1) offer_request(8'($urandom), 1'b0);
      pos   = FIRST_POS;
      tries = 0;
      while (pos < COEFF_COUNT && tries != cut_after) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            b = 8'(pos);
         end else if (pick < 25) begin
            b = 8'($urandom);
         end else begin
            b = 8'($urandom_range(0, pos));
         end
         offer_request(b, 1'b0);
         if (b <= pos) begin
            pos++;
         end
         tries++;
      end
   endtask

   initial begin
      int phase_start;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_stream_byte = 8'h00;
      req_start_req   = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // nothing running yet: drop these
      offer_request(8'hFF, 1'b0);
      offer_request(8'h00, 1'b0);
      // restart while the sign word is still being gathered
      offer_request(8'hFF, 1'b1);
      offer_request(8'h00, 1'b0);
      offer_request(8'h5A, 1'b0);
      offer_request(8'hAA, 1'b1);
      for (int i = 0; i < 7; i++) begin
         offer_request(8'(8'h01 << i), 1'b0);
      end
      // reject the top byte, take zero, reject one above, swap in place, take zero again
      offer_request(8'hFF, 1'b0);
      offer_request(8'h00, 1'b0);
      offer_request(8'(FIRST_POS + 2), 1'b0);
      offer_request(8'(FIRST_POS + 1), 1'b0);
      offer_request(8'h00, 1'b0);
      // restart in the index phase
      offer_request(8'h00, 1'b1);
      wait_all_results();

      // hold the result side off so the block backs up and stalls its input
      holds_asked <= holds_asked + 1;
      run_challenge(-1);
      run_challenge(12);
      wait_all_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               idle_pct = 70;
               stall_pct <= 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct <= 70;
            end
            default: begin
               idle_pct = 11;
               stall_pct <= 11;
            end
         endcase
         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
               run_challenge($urandom_range(1, 40));
            end else begin
               run_challenge(-1);
            end
            // stray bytes between challenges
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 3)) offer_request(8'($urandom), 1'b0);
            end
         end
         wait_all_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Summary: %0d requests taken, %0d challenges completed, %0d restarts mid-run",
               requests_sent, challenges_done, restarts);
      $display("Summary: %0d result words checked over 4 idle/stall phases, %0d long hold-off(s)",
               words_checked, holds_served);
      if (mismatches == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
